### design/tmr16_pkg.sv
`timescale 1ns / 1ps

package tmr16_pkg;

    // Counter width
    localparam int COUNT_WIDTH = 16;

    // Shared prescaler width
    localparam int PRESCALE_WIDTH = 10;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register addresses
    localparam logic [2:0] ADDR_CONTROL = 3'd0;
    localparam logic [2:0] ADDR_MASK    = 3'd1;
    localparam logic [2:0] ADDR_FLAGS   = 3'd2;
    localparam logic [2:0] ADDR_COUNTER = 3'd3;
    localparam logic [2:0] ADDR_COMPARE = 3'd4;

    // Clock select codes
    localparam logic [2:0] CS_STOPPED = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;
    localparam logic [2:0] CS_PIN_FALL = 3'd6;
    localparam logic [2:0] CS_PIN_RISE = 3'd7;

    // Flag and mask bit positions
    localparam int FLAG_OVF = 0;
    localparam int FLAG_CMP = 1;

    typedef logic [COUNT_WIDTH-1:0] t_count;

endpackage

### design/timer16_ctc_prescaled.sv
`timescale 1ns / 1ps

// Timer/counter with clear-on-compare mode and a shared 10-bit prescaler.
// A word accepted sits in the input register, and its result word is written to
// the result register as the word leaves the input stage.
// Throughput: one word per cycle; the input stalls only while the result
// register is full and its receiver stalls.
// Reset (i_rst_n low, synchronous): all timer state to zero, both stages empty.
module timer16_ctc_prescaled (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_reg_addr,
    input  logic [15:0] i_write_data,
    input  logic        i_pin_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic        o_irq,
    output logic [15:0] o_count_now
);

    localparam int CW = tmr16_pkg::COUNT_WIDTH;
    localparam int PW = tmr16_pkg::PRESCALE_WIDTH;

    // Input stage
    logic        r_in_v;
    logic [1:0]  r_op;
    logic [2:0]  r_addr;
    logic [15:0] r_wdata;
    logic        r_pin;

    // Result stage
    logic        r_out_v;
    logic [15:0] r_rdata;
    logic        r_irq;
    logic [15:0] r_cnt_out;

    // Timer state
    tmr16_pkg::t_count r_counter, n_counter;
    tmr16_pkg::t_count r_compare, n_compare;
    logic              r_ctc, n_ctc;
    logic [2:0]        r_csel, n_csel;
    logic [1:0]        r_mask, n_mask;
    logic [1:0]        r_flags, n_flags;
    logic [PW-1:0]     r_presc, n_presc;
    logic              r_pin_prev, n_pin_prev;

    logic        advance;
    logic        in_accept;
    logic        tick_event;
    logic        match;
    logic [15:0] n_rdata;
    logic [31:0] cnt_wide;
    logic [31:0] cmp_wide;
    logic [31:0] wdata_wide;

    assign advance    = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign cnt_wide   = 32'(r_counter);
    assign cmp_wide   = 32'(r_compare);
    assign wdata_wide = 32'(i_write_data);

    // Timer clock event for this tick
    always_comb begin
        case (r_csel)
            tmr16_pkg::CS_DIV1:     tick_event = 1'b1;
            tmr16_pkg::CS_DIV8:     tick_event = &r_presc[2:0];
            tmr16_pkg::CS_DIV64:    tick_event = &r_presc[5:0];
            tmr16_pkg::CS_DIV256:   tick_event = &r_presc[7:0];
            tmr16_pkg::CS_DIV1024:  tick_event = &r_presc[9:0];
            tmr16_pkg::CS_PIN_FALL: tick_event = r_pin_prev && !r_pin;
            tmr16_pkg::CS_PIN_RISE: tick_event = !r_pin_prev && r_pin;
            default:                tick_event = 1'b0;
        endcase
    end

    assign match = (r_counter == r_compare);

    // Next state and read data for the word in the input stage
    always_comb begin
        n_counter  = r_counter;
        n_compare  = r_compare;
        n_ctc      = r_ctc;
        n_csel     = r_csel;
        n_mask     = r_mask;
        n_flags    = r_flags;
        n_presc    = r_presc;
        n_pin_prev = r_pin_prev;
        n_rdata    = '0;
        case (r_op)
            tmr16_pkg::OP_TICK: begin
                if (tick_event) begin
                    if (match) begin
                        n_flags[tmr16_pkg::FLAG_CMP] = 1'b1;
                    end
                    if (&r_counter) begin
                        n_flags[tmr16_pkg::FLAG_OVF] = 1'b1;
                        n_counter = '0;
                    end else if (match && r_ctc) begin
                        n_counter = '0;
                    end else begin
                        n_counter = r_counter + 1'b1;
                    end
                end
                n_presc    = r_presc + 1'b1;
                n_pin_prev = r_pin;
            end
            tmr16_pkg::OP_READ: begin
                unique case (r_addr)
                    tmr16_pkg::ADDR_CONTROL: n_rdata = {12'd0, r_ctc, r_csel};
                    tmr16_pkg::ADDR_MASK:    n_rdata = {14'd0, r_mask};
                    tmr16_pkg::ADDR_FLAGS:   n_rdata = {14'd0, r_flags};
                    tmr16_pkg::ADDR_COUNTER: n_rdata = cnt_wide[15:0];
                    tmr16_pkg::ADDR_COMPARE: n_rdata = cmp_wide[15:0];
                    default:                 n_rdata = '0;
                endcase
            end
            tmr16_pkg::OP_WRITE: begin
                unique case (r_addr)
                    tmr16_pkg::ADDR_CONTROL: begin
                        n_csel = r_wdata[2:0];
                        n_ctc  = r_wdata[3];
                    end
                    tmr16_pkg::ADDR_MASK:    n_mask  = r_wdata[1:0];
                    tmr16_pkg::ADDR_FLAGS:   n_flags = r_flags & ~r_wdata[1:0];
                    tmr16_pkg::ADDR_COUNTER: n_counter = CW'(32'(r_wdata));
                    tmr16_pkg::ADDR_COMPARE: n_compare = CW'(32'(r_wdata));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_accept) begin
            r_in_v <= 1'b1;
        end else if (advance) begin
            r_in_v <= 1'b0;
        end
        if (in_accept) begin
            r_op    <= i_operation;
            r_addr  <= i_reg_addr;
            r_wdata <= wdata_wide[15:0];
            r_pin   <= i_pin_level;
        end
    end

    // Timer state, updated as a word leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter  <= '0;
            r_compare  <= '0;
            r_ctc      <= 1'b0;
            r_csel     <= tmr16_pkg::CS_STOPPED;
            r_mask     <= '0;
            r_flags    <= '0;
            r_presc    <= '0;
            r_pin_prev <= 1'b0;
        end else if (advance) begin
            r_counter  <= n_counter;
            r_compare  <= n_compare;
            r_ctc      <= n_ctc;
            r_csel     <= n_csel;
            r_mask     <= n_mask;
            r_flags    <= n_flags;
            r_presc    <= n_presc;
            r_pin_prev <= n_pin_prev;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
        if (advance) begin
            r_rdata   <= n_rdata;
            r_irq     <= |(n_flags & n_mask);
            r_cnt_out <= 16'(32'(n_counter));
        end
    end

    assign o_out_valid = r_out_v;
    assign o_read_data = r_rdata;
    assign o_irq       = r_irq;
    assign o_count_now = r_cnt_out;

endmodule

### design/tmr16_chk.sv
`timescale 1ns / 1ps

module tmr16_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_read_data,
    input logic        o_irq,
    input logic [15:0] o_count_now
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // Input only backs up when the output side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result word dropped");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_read_data) && $stable(o_irq) && $stable(o_count_now)))
        else $error("stalled result word changed");

endmodule

bind timer16_ctc_prescaled tmr16_chk u_tmr16_chk (.*);

### tb/sv/timer16_ctc_prescaled_test.sv
`timescale 1ns / 1ps

module timer16_ctc_prescaled_test;

    import tmr16_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 920;
    localparam int QUIET_FROM   = 820;
    localparam int TABLE_ROWS   = 27;

    // Codes the package leaves out
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [2:0]  ADDR_UNUSED_LO = 3'd5;
    localparam logic [2:0]  ADDR_UNUSED_HI = 3'd7;
    localparam logic [15:0] CTRL_CTC       = 16'h0008;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  addr;
        logic [15:0] data;
        logic        pin;
    } t_word;

    typedef struct packed {
        logic [15:0] rdata;
        logic        irq;
        logic [15:0] count;
    } t_result;

    typedef struct packed {
        t_word   word;
        logic    fixed;
        t_result res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_operation;
    logic [2:0]  i_reg_addr;
    logic [15:0] i_write_data;
    logic        i_pin_level;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_read_data;
    logic        o_irq;
    logic [15:0] o_count_now;

    // Predicted timer state
    t_count     tm_counter  = '0;
    t_count     tm_compare  = '0;
    logic       tm_ctc      = 1'b0;
    logic [2:0] tm_clksel   = CS_STOPPED;
    logic [1:0] tm_mask     = '0;
    logic [1:0] tm_flags    = '0;
    logic [PRESCALE_WIDTH-1:0] tm_prescale = '0;
    logic       tm_pin_prev = 1'b0;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      idle_pct       = 0;
    bit      hold_req       = 1'b0;

    // Directed words; a typed result is used where it is obvious
    t_row stim_table [TABLE_ROWS] = '{
        '{'{OP_READ,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b1, '{16'h0000, 1'b0, 16'h0000}},
        '{'{OP_READ,   ADDR_UNUSED_HI, 16'h0000, 1'b0}, 1'b1, '{16'h0000, 1'b0, 16'h0000}},
        '{'{OP_UNUSED, ADDR_CONTROL,   16'hFFFF, 1'b1}, 1'b1, '{16'h0000, 1'b0, 16'h0000}},
        '{'{OP_WRITE,  ADDR_CONTROL,   {13'h0, CS_PIN_RISE}, 1'b0}, 1'b1,
          '{16'h0000, 1'b0, 16'h0000}},
        // first tick after reset with the pin high is a rising edge
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b1}, 1'b1, '{16'h0000, 1'b0, 16'h0001}},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_COUNTER,   16'hFFFF, 1'b0}, 1'b1, '{16'h0000, 1'b0, 16'hFFFF}},
        '{'{OP_WRITE,  ADDR_MASK,      16'hFFFF, 1'b0}, 1'b1, '{16'h0000, 1'b1, 16'hFFFF}},
        '{'{OP_WRITE,  ADDR_FLAGS,     16'hFFFF, 1'b0}, 1'b1, '{16'h0000, 1'b0, 16'hFFFF}},
        '{'{OP_WRITE,  ADDR_CONTROL,   {13'h0, CS_DIV1}, 1'b0}, 1'b0, '0},
        // wrap from all ones
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b1, '{16'h0000, 1'b1, 16'h0000}},
        '{'{OP_READ,   ADDR_FLAGS,     16'h0000, 1'b0}, 1'b1, '{16'h0001, 1'b1, 16'h0000}},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_FLAGS,     16'h0001, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_COMPARE,   16'h0006, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_CONTROL,   CTRL_CTC | {13'h0, CS_DIV1}, 1'b0}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_COUNTER,   16'h0005, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_READ,   ADDR_FLAGS,     16'h0000, 1'b0}, 1'b0, '0},
        // counter above compare in clear-on-compare mode runs on to the wrap
        '{'{OP_WRITE,  ADDR_COUNTER,   16'h000A, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_COUNTER,   16'hFFFF, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b1}, 1'b0, '0},
        '{'{OP_WRITE,  ADDR_CONTROL,   {13'h0, CS_PIN_FALL}, 1'b0}, 1'b0, '0},
        '{'{OP_TICK,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b0, '0},
        '{'{OP_READ,   ADDR_CONTROL,   16'h0000, 1'b0}, 1'b0, '0}
    };

    timer16_ctc_prescaled u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_pin_level  (i_pin_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_irq        (o_irq),
        .o_count_now  (o_count_now)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the predicted timer by one word and return its result
    function automatic t_result timer_predict(t_word w);
        t_result r;
        logic    fire;
        logic    match;
        r = '0;
        case (w.op)
            OP_TICK: begin
                case (tm_clksel)
                    CS_DIV1:     fire = 1'b1;
                    CS_DIV8:     fire = &tm_prescale[2:0];
                    CS_DIV64:    fire = &tm_prescale[5:0];
                    CS_DIV256:   fire = &tm_prescale[7:0];
                    CS_DIV1024:  fire = &tm_prescale[9:0];
                    CS_PIN_FALL: fire = tm_pin_prev && !w.pin;
                    CS_PIN_RISE: fire = !tm_pin_prev && w.pin;
                    default:     fire = 1'b0;
                endcase
                if (fire) begin
                    match = (tm_counter == tm_compare);
                    if (match)
                        tm_flags[FLAG_CMP] = 1'b1;
                    if (&tm_counter) begin
                        tm_flags[FLAG_OVF] = 1'b1;
                        tm_counter = '0;
                    end else if (match && tm_ctc) begin
                        tm_counter = '0;
                    end else begin
                        tm_counter = tm_counter + 1'b1;
                    end
                end
                tm_prescale = tm_prescale + 1'b1;
                tm_pin_prev = w.pin;
            end
            OP_READ: begin
                case (w.addr)
                    ADDR_CONTROL: r.rdata = {12'h0, tm_ctc, tm_clksel};
                    ADDR_MASK:    r.rdata = {14'h0, tm_mask};
                    ADDR_FLAGS:   r.rdata = {14'h0, tm_flags};
                    ADDR_COUNTER: r.rdata = tm_counter;
                    ADDR_COMPARE: r.rdata = tm_compare;
                    default:      r.rdata = '0;
                endcase
            end
            OP_WRITE: begin
                case (w.addr)
                    ADDR_CONTROL: begin
                        tm_clksel = w.data[2:0];
                        tm_ctc    = w.data[3];
                    end
                    ADDR_MASK:    tm_mask    = w.data[1:0];
                    ADDR_FLAGS:   tm_flags   = tm_flags & ~w.data[1:0];
                    ADDR_COUNTER: tm_counter = w.data;
                    ADDR_COMPARE: tm_compare = w.data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.irq   = |(tm_flags & tm_mask);
        r.count = tm_counter;
        return r;
    endfunction

    // Offer one word, optionally after a gap, and log its result once taken
    task automatic send_word(input t_word w, input logic fixed, input t_result fixed_res);
        int      gap;
        t_result pred;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= w.op;
        i_reg_addr   <= w.addr;
        i_write_data <= w.data;
        i_pin_level  <= w.pin;
        do @(posedge i_clk); while (o_in_stall);
        pred = timer_predict(w);
        pending_results.push_back(fixed ? fixed_res : pred);
    endtask

    // Stimulus: directed table, then random words
    initial begin : stimulus
        t_word w;
        int    pick;
        int    iter;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_operation  <= OP_TICK;
        i_reg_addr   <= ADDR_CONTROL;
        i_write_data <= '0;
        i_pin_level  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < TABLE_ROWS; k++)
            send_word(stim_table[k].word, stim_table[k].fixed, stim_table[k].res);

        iter = 0;
        while (iter < RANDOM_ITEMS) begin
            // pick a new idle level now and then
            if (iter % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (iter >= QUIET_FROM)
                idle_pct = 0;
            if (iter == 300)
                hold_req = 1'b1;
            if (iter == 600) begin
                i_in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end

            w.op    = OP_TICK;
            w.addr  = 3'($urandom_range(0, 7));
            w.data  = 16'($urandom_range(0, 65535));
            w.pin   = 1'($urandom_range(0, 1));
            pick    = $urandom_range(0, 99);
            if (pick < 60) begin
                w.op = OP_TICK;
            end else if (pick < 66) begin
                w.op = OP_READ;
            end else if (pick < 72) begin
                w.op   = OP_WRITE;
                w.addr = ADDR_CONTROL;
                if ($urandom_range(0, 9) < 3)
                    w.data[2:0] = CS_DIV1;
            end else if (pick < 78) begin
                w.op   = OP_WRITE;
                w.addr = ADDR_COUNTER;
                case ($urandom_range(0, 3))
                    0:       ;
                    1:       w.data = 16'hFFFF - 16'($urandom_range(0, 4));
                    2:       w.data = tm_compare - 16'($urandom_range(0, 4));
                    default: w.data = tm_compare + 16'($urandom_range(0, 4));
                endcase
            end else if (pick < 84) begin
                w.op   = OP_WRITE;
                w.addr = ADDR_COMPARE;
                case ($urandom_range(0, 2))
                    0:       ;
                    1:       w.data = tm_counter + 16'($urandom_range(0, 6));
                    default: w.data = 16'($urandom_range(0, 8));
                endcase
            end else if (pick < 89) begin
                w.op   = OP_WRITE;
                w.addr = ADDR_FLAGS;
            end else if (pick < 93) begin
                w.op   = OP_WRITE;
                w.addr = ADDR_MASK;
            end else if (pick < 96) begin
                w.op    = OP_WRITE;
                w.addr  = 3'($urandom_range(ADDR_UNUSED_LO, ADDR_UNUSED_HI));
            end else begin
                w.op    = OP_UNUSED;
            end
            send_word(w, 1'b0, '0);
            iter++;
        end

        // drain
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side stall: random bursts, plus one long hold-off on request
    initial begin : result_stall
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: read_data %h irq %b count_now %h",
                         $time, o_read_data, o_irq, o_count_now);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.rdata) begin
                    $display("%0t: read_data mismatch: expected %h, actual %h",
                             $time, want.rdata, o_read_data);
                    mismatch_count++;
                end
                if (o_irq !== want.irq) begin
                    $display("%0t: irq mismatch: expected %b, actual %b",
                             $time, want.irq, o_irq);
                    mismatch_count++;
                end
                if (o_count_now !== want.count) begin
                    $display("%0t: count_now mismatch: expected %h, actual %h",
                             $time, want.count, o_count_now);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding",
                     $time, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
